>>> design/tsb_pkg.sv
// ----------------------------------------------------------------------------
// tsb_pkg: shared types and constants of the bilinear texture sampler
// Holds the sample request passed from the front end to the back end.
// ----------------------------------------------------------------------------
package tsb_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned IdxW      = 12;   // holds index up to 4095
  localparam int unsigned FracW     = 16;

  localparam logic [2:0] RegWidth  = 3'd0;
  localparam logic [2:0] RegHeight = 3'd1;
  localparam logic [2:0] RegClampU = 3'd2;
  localparam logic [2:0] RegClampV = 3'd3;
  localparam logic [2:0] RegLinear = 3'd4;

  // classified sample request
  typedef struct packed {
    logic             linear;
    logic [AddrW-1:0] a00;
    logic [AddrW-1:0] a01;
    logic [AddrW-1:0] a10;
    logic [AddrW-1:0] a11;
    logic [FracW-1:0] fu;
    logic [FracW-1:0] fv;
  } smp_req_t;

endpackage

>>> design/tsb_front.sv
// ----------------------------------------------------------------------------
// tsb_front: coordinate front end
// Normalizes and scales u/v, computes the four texel addresses and weights.
// Two register stages; holds when the queue is full.
// ----------------------------------------------------------------------------
module tsb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       coord_u_i,
  input  logic [31:0]       coord_v_i,
  input  logic [8:0]        width_i,
  input  logic [8:0]        height_i,
  input  logic              clamp_u_i,
  input  logic              clamp_v_i,
  input  logic              linear_i,
  output logic              req_valid_o,
  input  logic              req_ready_i,
  output tsb_pkg::smp_req_t req_o,
  output logic              busy_o
);

  logic [8:0]  w_s, h_s;
  logic [16:0] nu, nv;

  // stage 1 registers: scaled positions
  logic        s1_valid_q;
  logic [28:0] su_q, sv_q;
  logic [8:0]  w_q, h_q;
  logic        lin_q;
  logic        s2_valid_q;
  tsb_pkg::smp_req_t req_q, req_d;
  logic        s2_free, s1_free;

  // saturate sizes
  always_comb begin
    w_s = (width_i == 9'd0) ? 9'd1 :
          (width_i > 9'(tsb_pkg::MaxWidth)) ? 9'(tsb_pkg::MaxWidth) : width_i;
    h_s = (height_i == 9'd0) ? 9'd1 :
          (height_i > 9'(tsb_pkg::MaxHeight)) ? 9'(tsb_pkg::MaxHeight) : height_i;
  end

  // clamp or wrap
  always_comb begin
    if (clamp_u_i) begin
      if (coord_u_i[31]) nu = 17'd0;
      else if (coord_u_i > 32'h10000) nu = 17'h10000;
      else nu = coord_u_i[16:0];
    end else begin
      nu = {1'b0, coord_u_i[15:0]};
    end
    if (clamp_v_i) begin
      if (coord_v_i[31]) nv = 17'd0;
      else if (coord_v_i > 32'h10000) nv = 17'h10000;
      else nv = coord_v_i[16:0];
    end else begin
      nv = {1'b0, coord_v_i[15:0]};
    end
  end

  assign s2_free    = !s2_valid_q || req_ready_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign busy_o     = s1_valid_q || s2_valid_q;

  // stage 1: scale by size minus one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      su_q  <= 29'(nu) * 29'(w_s - 9'd1);
      sv_q  <= 29'(nv) * 29'(h_s - 9'd1);
      w_q   <= w_s;
      h_q   <= h_s;
      lin_q <= linear_i;
    end
  end

  // stage 2: neighbor indices and addresses
  always_comb begin
    logic [11:0] iu, iv, iu1, iv1;
    logic [23:0] r0, r1;
    iu  = su_q[27:16];
    iv  = sv_q[27:16];
    iu1 = (iu + 12'd1 > 12'(w_q) - 12'd1) ? 12'(w_q) - 12'd1 : iu + 12'd1;
    iv1 = (iv + 12'd1 > 12'(h_q) - 12'd1) ? 12'(h_q) - 12'd1 : iv + 12'd1;
    r0  = iv * 12'(w_q);
    r1  = iv1 * 12'(w_q);
    req_d.linear = lin_q;
    req_d.a00 = r0[15:0] + 16'(iu);
    req_d.a01 = r0[15:0] + 16'(iu1);
    req_d.a10 = r1[15:0] + 16'(iu);
    req_d.a11 = r1[15:0] + 16'(iu1);
    req_d.fu  = su_q[15:0];
    req_d.fv  = sv_q[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_free) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_valid_q) req_q <= req_d;
  end

  assign req_valid_o = s2_valid_q;
  assign req_o       = req_q;

endmodule

>>> design/tsb_queue.sv
// ----------------------------------------------------------------------------
// tsb_queue: two-entry request queue between front and back end
// ----------------------------------------------------------------------------
module tsb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  tsb_pkg::smp_req_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output tsb_pkg::smp_req_t rd_data_o
);

  tsb_pkg::smp_req_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;
  assign rd_data_o = mem_q[rp_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> design/tsb_back.sv
// ----------------------------------------------------------------------------
// tsb_back: texel memory and blend sequencer
// Owns the single-port texel store. A sample reads one (nearest) or four
// (linear) texels; the four linear texels are blended channel-parallel.
// ----------------------------------------------------------------------------
module tsb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [15:0]       wr_addr_i,
  input  logic [31:0]       wr_data_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  tsb_pkg::smp_req_t req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       out_data_o,
  output logic              busy_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StHoriz = 3'd2;
  localparam logic [2:0] StVert  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  logic [31:0] store_q [65536];
  logic [31:0] rdata_q;
  logic [2:0]  st_q;
  logic [2:0]  cnt_q;          // reads issued
  logic [1:0]  got_q;          // reads captured
  logic        rd_pend_q;
  tsb_pkg::smp_req_t req_q;
  logic [31:0] t_q [4];
  logic [23:0] top_q [4], bot_q [4];
  logic [31:0] res_q;
  logic        ov_q;
  logic [15:0] raddr;
  logic        nreads_last;

  assign req_ready_o = (st_q == StIdle) && !wr_en_i;
  assign busy_o      = st_q != StIdle;

  always_comb begin
    unique case (cnt_q[1:0])
      2'd0: raddr = req_q.a00;
      2'd1: raddr = req_q.a01;
      2'd2: raddr = req_q.a10;
      default: raddr = req_q.a11;
    endcase
  end
  assign nreads_last = req_q.linear ? (cnt_q == 3'd3) : (cnt_q == 3'd0);

  // single-port texel memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i) store_q[wr_addr_i] <= wr_data_i;
    else if (st_q == StRead && cnt_q != 3'd4) rdata_q <= store_q[raddr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; cnt_q <= 3'd0; got_q <= 2'd0;
      rd_pend_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: if (req_valid_i && !wr_en_i) begin
          st_q <= StRead; cnt_q <= 3'd0; got_q <= 2'd0; rd_pend_q <= 1'b0;
        end
        StRead: if (!wr_en_i) begin
          if (rd_pend_q) got_q <= got_q + 2'd1;
          if (cnt_q != 3'd4 && !(rd_pend_q && nreads_last && cnt_q != 3'd0)) begin
            rd_pend_q <= 1'b1;
            cnt_q <= cnt_q + 3'd1;
          end else begin
            rd_pend_q <= 1'b0;
          end
          if (rd_pend_q && ((req_q.linear && got_q == 2'd3) || !req_q.linear))
            st_q <= req_q.linear ? StHoriz : StOut;
        end else if (rd_pend_q) begin
          // write stole the port: capture and retry nothing, data held
          got_q <= got_q + 2'd1; rd_pend_q <= 1'b0;
          if ((req_q.linear && got_q == 2'd3) || !req_q.linear)
            st_q <= req_q.linear ? StHoriz : StOut;
        end
        StHoriz: st_q <= StVert;
        StVert:  st_q <= StOut;
        default: if (!ov_q || out_ready_i) begin
          ov_q <= 1'b1; st_q <= StIdle;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && req_valid_i && !wr_en_i) req_q <= req_i;
    if (rd_pend_q && (st_q == StRead)) t_q[got_q] <= rdata_q;
    if (st_q == StHoriz) begin
      for (int k = 0; k < 4; k++) begin
        top_q[k] <= 24'(t_q[0][8*k +: 8]) * (24'h10000 - 24'(req_q.fu))
                  + 24'(t_q[1][8*k +: 8]) * 24'(req_q.fu);
        bot_q[k] <= 24'(t_q[2][8*k +: 8]) * (24'h10000 - 24'(req_q.fu))
                  + 24'(t_q[3][8*k +: 8]) * 24'(req_q.fu);
      end
    end
    if (st_q == StVert) begin
      for (int k = 0; k < 4; k++) begin
        logic [40:0] s;
        s = 41'(top_q[k]) * (41'h10000 - 41'(req_q.fv))
          + 41'(bot_q[k]) * 41'(req_q.fv)
          + 41'h80000000;
        res_q[8*k +: 8] <= s[39:32];
      end
    end
    if (st_q == StOut && (!ov_q || out_ready_i)) begin
      if (!req_q.linear) out_data_o <= t_q[0];
      else out_data_o <= res_q;
    end
  end

  assign out_valid_o = ov_q;

endmodule

>>> design/texture_sampler_bilinear_core.sv
// ----------------------------------------------------------------------------
// texture_sampler_bilinear_core: RGBA8 texture sampler, nearest or bilinear
// A write request loads one texel into the single-port 64K x 32 store, but is
// held off while any sample is still in flight, so a write never overtakes an
// earlier sample. A sample request passes a two-stage coordinate front end
// into a two-entry queue; the back end takes one sample at a time, reads one
// texel (nearest) or four texels (bilinear) from the store port, blends the
// four horizontally then vertically for bilinear, and holds the result in an
// output register. Configuration is to be written only while the block is
// idle: the user must keep to this, and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module texture_sampler_bilinear_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] texel_address_i,
  input  logic [31:0] texel_data_i,
  input  logic [31:0] coord_u_i,
  input  logic [31:0] coord_v_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o
);

  logic [8:0] width_q, height_q;
  logic       clamp_u_q, clamp_v_q, linear_q;
  logic       f_ready, f_valid, q_ready, q_valid, b_ready, wr_en;
  logic       f_busy, b_busy, smp_busy;
  tsb_pkg::smp_req_t f_req, q_req;
  logic [31:0] pix;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd256; height_q <= 9'd256;
      clamp_u_q <= 1'b0; clamp_v_q <= 1'b0; linear_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsb_pkg::RegWidth:  width_q   <= cfg_data_i;
        tsb_pkg::RegHeight: height_q  <= cfg_data_i;
        tsb_pkg::RegClampU: clamp_u_q <= cfg_data_i[0];
        tsb_pkg::RegClampV: clamp_v_q <= cfg_data_i[0];
        tsb_pkg::RegLinear: linear_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // writes wait until every earlier sample has read the store
  assign smp_busy   = f_busy || q_valid || b_busy;
  assign wr_en      = in_valid_i && !action_i && !smp_busy;
  assign in_ready_o = action_i ? f_ready : !smp_busy;

  tsb_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (in_valid_i && action_i), .in_ready_o (f_ready),
    .coord_u_i, .coord_v_i,
    .width_i (width_q), .height_i (height_q),
    .clamp_u_i (clamp_u_q), .clamp_v_i (clamp_v_q), .linear_i (linear_q),
    .req_valid_o (f_valid), .req_ready_i (q_ready), .req_o (f_req),
    .busy_o (f_busy)
  );

  tsb_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (f_valid), .wr_ready_o (q_ready), .wr_data_i (f_req),
    .rd_valid_o (q_valid), .rd_ready_i (b_ready), .rd_data_o (q_req)
  );

  tsb_back u_back (
    .clk_i, .rst_ni,
    .wr_en_i (wr_en), .wr_addr_i (texel_address_i), .wr_data_i (texel_data_i),
    .req_valid_i (q_valid), .req_ready_o (b_ready), .req_i (q_req),
    .out_valid_o, .out_ready_i, .out_data_o (pix), .busy_o (b_busy)
  );

  assign red_o   = pix[7:0];
  assign green_o = pix[15:8];
  assign blue_o  = pix[23:16];
  assign alpha_o = pix[31:24];

endmodule

>>> design/tsb_checker.sv
// ----------------------------------------------------------------------------
// tsb_checker: port-level checks of the texture sampler
// ----------------------------------------------------------------------------
module tsb_port_checks (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       action_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_o
);

  // a stalled request stays offered with the same kind
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(action_i))
    else $error("request dropped");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o))
    else $error("result dropped");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result after reset");

endmodule

bind texture_sampler_bilinear_core tsb_port_checks u_tsb_checker (.*);
